// ----- rtl/core/pkbl_pkg.sv -----
package pkbl_pkg;

  localparam int unsigned TABLE_ENTRIES = 256;
  localparam int unsigned IDX_W = $clog2(TABLE_ENTRIES);

  localparam logic [63:0] NS_PER_S = 64'd1000000000;

  localparam logic [1:0] CFG_REFILL_RATE = 2'd0;
  localparam logic [1:0] CFG_BUCKET_CAP  = 2'd1;
  localparam logic [1:0] CFG_IDLE_INTVL  = 2'd2;

  localparam logic [1:0] STATUS_BUCKET   = 2'd0;
  localparam logic [1:0] STATUS_DISABLED = 2'd1;
  localparam logic [1:0] STATUS_FULL     = 2'd2;

  typedef struct packed {
    logic [31:0] key;
    logic [31:0] tokens;
    logic [63:0] refill_time;
    logic [63:0] access_time;
  } row_t;

  typedef struct packed {
    logic        big;
    logic [31:0] add;
  } refill_res_t;

endpackage

// ----- rtl/core/pkbl_refill.sv -----
module pkbl_refill (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 go_i,
  input  logic [63:0]          elapsed_i,
  input  logic [31:0]          rate_i,
  output logic                 done_o,
  output pkbl_pkg::refill_res_t res_o
);

  localparam logic [3:0] R_IDLE = 4'd0;
  localparam logic [3:0] R_LO   = 4'd1;
  localparam logic [3:0] R_HI   = 4'd2;
  localparam logic [3:0] R_SUM  = 4'd3;
  localparam logic [3:0] R_EST  = 4'd4;
  localparam logic [3:0] R_QE   = 4'd5;
  localparam logic [3:0] R_QM   = 4'd6;
  localparam logic [3:0] R_REM  = 4'd7;
  localparam logic [3:0] R_FIX  = 4'd8;

  // floor(2^62 / 1e9) = 2^32 + RECIP_LO
  localparam logic [31:0] RECIP_LO = 32'd316718722;
  localparam logic [31:0] NS_LO    = 32'(pkbl_pkg::NS_PER_S);
  localparam logic [31:0] NS_X2    = 32'd2000000000;

  logic [3:0]  phase_q, phase_d;
  logic [63:0] prod_lo_q, prod_hi_q;
  logic [61:0] x_q;
  logic [63:0] mul_q;
  logic [31:0] q_q, r_q;
  logic        big_q, done_q;

  logic [63:0] top;
  logic        top_big;

  assign top     = prod_hi_q + {32'd0, prod_lo_q[63:32]};
  assign top_big = top >= pkbl_pkg::NS_PER_S;

  always_comb begin
    phase_d = phase_q;
    unique case (phase_q)
      R_IDLE: if (go_i) phase_d = R_LO;
      R_LO:   phase_d = R_HI;
      R_HI:   phase_d = R_SUM;
      R_SUM:  phase_d = top_big ? R_IDLE : R_EST;
      R_EST:  phase_d = R_QE;
      R_QE:   phase_d = R_QM;
      R_QM:   phase_d = R_REM;
      R_REM:  phase_d = R_FIX;
      R_FIX:  phase_d = R_IDLE;
      default: phase_d = R_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= R_IDLE;
      done_q  <= 1'b0;
    end else begin
      phase_q <= phase_d;
      done_q  <= ((phase_q == R_SUM) && top_big) || (phase_q == R_FIX);
    end
  end

  // quotient estimate is low by at most two, fixed from the remainder
  always_ff @(posedge clk_i) begin
    case (phase_q)
      R_LO: prod_lo_q <= 64'(elapsed_i[31:0]) * 64'(rate_i);
      R_HI: prod_hi_q <= 64'(elapsed_i[63:32]) * 64'(rate_i);
      R_SUM: begin
        big_q <= top_big;
        x_q   <= {top[29:0], prod_lo_q[31:0]};
        q_q   <= 32'd0;
      end
      R_EST: mul_q <= 64'(x_q[61:30]) * 64'(RECIP_LO);
      R_QE:  q_q   <= x_q[61:30] + mul_q[63:32];
      R_QM:  mul_q <= 64'(q_q) * pkbl_pkg::NS_PER_S;
      R_REM: r_q   <= x_q[31:0] - mul_q[31:0];
      R_FIX: begin
        if (r_q >= NS_X2) q_q <= q_q + 32'd2;
        else if (r_q >= NS_LO) q_q <= q_q + 32'd1;
      end
      default: ;
    endcase
  end

  assign done_o    = done_q;
  assign res_o.big = big_q;
  assign res_o.add = q_q;

endmodule

// ----- rtl/core/per_key_token_bucket_limiter_core.sv -----
// Per-key token bucket limiter. Assert start for one cycle with client_key_i,
// cost_i and now_ns_i while busy is low; exactly one result follows on
// result_valid_o, held for that single cycle only, since the receiver cannot
// stall it. Every request scans the whole bucket table, one row per cycle
// from a synchronous-read memory with separate read and write addresses,
// doing idle eviction and key lookup in the same pass. A charged bucket then
// passes through the refill unit (the refill quotient is formed by two
// 32x32 partial products and a reciprocal multiply by 1/1e9 with a small
// correction) and the table write; when the limiter is disabled or the table
// is full, the result follows the scan directly. busy drops in the cycle the
// result appears, so the next word can be taken then. Registers may be
// written only while busy is low and no result is pending.
module per_key_token_bucket_limiter_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [31:0] client_key_i,
  input  logic [31:0] cost_i,
  input  logic [63:0] now_ns_i,
  output logic        result_valid_o,
  output logic        allowed_o,
  output logic [1:0]  status_o,
  output logic [31:0] tokens_left_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i
);

  localparam int unsigned N = pkbl_pkg::TABLE_ENTRIES;
  localparam int unsigned IW = pkbl_pkg::IDX_W;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_CHK  = 3'd1;
  localparam logic [2:0] S_SCAN = 3'd2;
  localparam logic [2:0] S_DEC  = 3'd3;
  localparam logic [2:0] S_REF  = 3'd4;
  localparam logic [2:0] S_UPD  = 3'd5;
  localparam logic [2:0] S_CHG  = 3'd6;

  logic [2:0]  state_q, state_d;
  logic [31:0] rate_q, cap_q, idle_q;
  logic [63:0] last_sweep_q;
  logic [N-1:0] valid_q;

  logic [31:0] key_q, cost_q, tok_q;
  logic [63:0] now_q, interval_q, refill_q, elapsed_q;
  logic        sweep_q, hit_q, free_q;
  logic [IW-1:0] scan_idx_q, slot_q, free_idx_q, rd_addr;

  pkbl_pkg::row_t table_q [N];
  pkbl_pkg::row_t rdata_q, wdata;
  logic           mem_we;

  logic        res_valid_q, allowed_q;
  logic [1:0]  status_q;
  logic [31:0] tokens_q;

  logic        ref_go, ref_done;
  pkbl_pkg::refill_res_t ref_res;

  logic        evict, eff_valid, scan_last;
  logic [32:0] sum;
  logic [31:0] new_tok;

  assign cfg_ready_o = 1'b1;
  assign busy        = state_q != S_IDLE;

  assign scan_last = scan_idx_q == IW'(N - 1);
  assign rd_addr   = (state_q == S_CHK) ? '0 : scan_idx_q + IW'(1);
  assign evict     = sweep_q && valid_q[scan_idx_q] &&
                     ((now_q - rdata_q.access_time) > interval_q);
  assign eff_valid = valid_q[scan_idx_q] && !evict;

  assign ref_go = (state_q == S_DEC) && (rate_q != 32'd0) && (hit_q || free_q);

  assign sum     = {1'b0, tok_q} + {1'b0, ref_res.add};
  assign new_tok = (ref_res.big || (sum > {1'b0, cap_q})) ? cap_q : sum[31:0];

  assign mem_we            = state_q == S_CHG;
  assign wdata.key         = key_q;
  assign wdata.tokens      = (tok_q >= cost_q) ? tok_q - cost_q : tok_q;
  assign wdata.refill_time = refill_q;
  assign wdata.access_time = now_q;

  always_ff @(posedge clk_i) begin
    if (mem_we) table_q[slot_q] <= wdata;
    rdata_q <= table_q[rd_addr];
  end

  pkbl_refill u_refill (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .go_i     (ref_go),
    .elapsed_i(elapsed_q),
    .rate_i   (rate_q),
    .done_o   (ref_done),
    .res_o    (ref_res)
  );

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: if (start) state_d = S_CHK;
      S_CHK:  state_d = S_SCAN;
      S_SCAN: if (scan_last) state_d = S_DEC;
      S_DEC:  state_d = ref_go ? S_REF : S_IDLE;
      S_REF:  if (ref_done) state_d = S_UPD;
      S_UPD:  state_d = S_CHG;
      S_CHG:  state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      rate_q       <= 32'd0;
      cap_q        <= 32'd100;
      idle_q       <= 32'd60;
      last_sweep_q <= 64'd0;
      valid_q      <= '0;
      res_valid_q  <= 1'b0;
    end else begin
      state_q     <= state_d;
      res_valid_q <= 1'b0;
      if (cfg_valid_i) begin
        unique case (cfg_index_i)
          pkbl_pkg::CFG_REFILL_RATE: rate_q <= cfg_data_i;
          pkbl_pkg::CFG_BUCKET_CAP:  cap_q  <= cfg_data_i;
          pkbl_pkg::CFG_IDLE_INTVL:  idle_q <= cfg_data_i;
          default: ;
        endcase
      end
      if ((state_q == S_CHK) && ((now_q - last_sweep_q) >= interval_q)) begin
        last_sweep_q <= now_q;
      end
      if ((state_q == S_SCAN) && evict) valid_q[scan_idx_q] <= 1'b0;
      if ((state_q == S_DEC) && ref_go && !hit_q) valid_q[free_idx_q] <= 1'b1;
      if ((state_q == S_DEC) && !ref_go) res_valid_q <= 1'b1;
      if (state_q == S_CHG) res_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: begin
        key_q      <= client_key_i;
        cost_q     <= cost_i;
        now_q      <= now_ns_i;
        interval_q <= 64'(idle_q) * pkbl_pkg::NS_PER_S;
      end
      S_CHK: begin
        sweep_q    <= (now_q - last_sweep_q) >= interval_q;
        scan_idx_q <= '0;
        hit_q      <= 1'b0;
        free_q     <= 1'b0;
      end
      S_SCAN: begin
        scan_idx_q <= scan_idx_q + IW'(1);
        if (eff_valid && !hit_q && (rdata_q.key == key_q)) begin
          hit_q    <= 1'b1;
          slot_q   <= scan_idx_q;
          tok_q    <= rdata_q.tokens;
          refill_q <= rdata_q.refill_time;
        end
        if (!eff_valid && !free_q) begin
          free_q     <= 1'b1;
          free_idx_q <= scan_idx_q;
        end
      end
      S_DEC: begin
        allowed_q <= 1'b1;
        tokens_q  <= 32'd0;
        status_q  <= (rate_q == 32'd0) ? pkbl_pkg::STATUS_DISABLED : pkbl_pkg::STATUS_FULL;
        if (hit_q) begin
          elapsed_q <= now_q - refill_q;
        end else begin
          slot_q    <= free_idx_q;
          tok_q     <= cap_q;
          refill_q  <= now_q;
          elapsed_q <= 64'd0;
        end
      end
      S_UPD: begin
        if (ref_res.big || (ref_res.add != 32'd0)) begin
          tok_q    <= new_tok;
          refill_q <= now_q;
        end
      end
      S_CHG: begin
        allowed_q <= tok_q >= cost_q;
        status_q  <= pkbl_pkg::STATUS_BUCKET;
        tokens_q  <= wdata.tokens;
      end
      default: ;
    endcase
  end

  assign result_valid_o = res_valid_q;
  assign allowed_o      = allowed_q;
  assign status_o       = status_q;
  assign tokens_left_o  = tokens_q;

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |=> busy)
    else $error("accepted word did not raise busy");

  a_single_strobe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |=> !result_valid_o)
    else $error("result strobe longer than one cycle");

  a_no_bucket_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && (status_o != pkbl_pkg::STATUS_BUCKET) |->
      allowed_o && (tokens_left_o == 32'd0))
    else $error("pass-through result carries tokens or rejects");

endmodule
